[design/pps_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and helpers for the packed pixel scanout block.
// No dependencies; every other file in the design imports this package.
package pps_pkg;

    localparam int VRAM_BYTES = 2097152;
    localparam int ADDR_W     = $clog2(VRAM_BYTES);
    localparam int COUNT_W    = 11;
    localparam int PITCH_W    = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int RGB_W      = 24;
    localparam int DATA_W     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_W-1:0] RST_WIDTH  = COUNT_W'(640);
    localparam logic [COUNT_W-1:0] RST_HEIGHT = COUNT_W'(480);
    localparam logic [PITCH_W-1:0] RST_STRIDE = PITCH_W'(1024);
    localparam logic [PITCH_W-1:0] RST_SKIP   = PITCH_W'(1024);

    localparam logic OP_FRAME_START = 1'b0;
    localparam logic OP_FETCH       = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIDEO_ENABLE  = 3'd0,
        CFG_MODE_BITS     = 3'd1,
        CFG_MODE_MAP      = 3'd2,
        CFG_ACTIVE_WIDTH  = 3'd3,
        CFG_ACTIVE_HEIGHT = 3'd4,
        CFG_ROW_STRIDE    = 3'd5,
        CFG_SKIP_BYTES    = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DEPTH_8BPP   = 3'd0,
        DEPTH_4BPP   = 3'd1,
        DEPTH_2BPP   = 3'd2,
        DEPTH_1BPP   = 3'd3,
        DEPTH_DIRECT = 3'd4
    } t_depth;

    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] fetch_data;
    } t_in;

    typedef struct packed {
        logic [RGB_W-1:0]  pixel_value;
        logic              pixel_valid;
        logic              is_direct_color;
        logic              line_end;
        logic              frame_end;
        logic [ADDR_W-1:0] next_address;
        logic              last;
    } t_out;

    // One classified item on its way from the front to the back
    typedef struct packed {
        logic              is_pixel;
        t_depth            depth;
        logic              video_en;
        logic              eol;
        logic              eof;
        logic [RGB_W-1:0]  data;
        logic [ADDR_W-1:0] next_address;
    } t_work;

    function automatic t_depth depth_of(input logic map, input logic [2:0] bits);
        t_depth d;
        if (!map) begin
            d = t_depth'({1'b0, bits[1:0]});
        end else begin
            case (bits)
                3'd7:    d = DEPTH_8BPP;
                3'd6:    d = DEPTH_4BPP;
                3'd5:    d = DEPTH_2BPP;
                3'd4:    d = DEPTH_1BPP;
                3'd0:    d = DEPTH_DIRECT;
                default: d = DEPTH_1BPP;
            endcase
        end
        return d;
    endfunction

endpackage

[design/pps_front.sv]
`timescale 1ns / 1ps
// Front end: configuration registers, line/column/row-base counters and
// fetch address generation. Pushes one classified item per transfer. Uses pps_pkg.
module pps_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  pps_pkg::t_in                 i_in,
    input  logic                         i_q_full,
    output logic                         o_push,
    output pps_pkg::t_work               o_work
);
    import pps_pkg::*;

    logic               r_video_en;
    logic [2:0]         r_mode_bits;
    logic               r_mode_map;
    logic [COUNT_W-1:0] r_width;
    logic [COUNT_W-1:0] r_height;
    logic [PITCH_W-1:0] r_stride;
    logic [PITCH_W-1:0] r_skip;

    logic [COUNT_W-1:0] r_col;
    logic [COUNT_W-1:0] r_line;
    logic [ADDR_W-1:0]  r_row_base;
    logic [COUNT_W-1:0] n_col;
    logic [COUNT_W-1:0] n_line;
    logic [ADDR_W-1:0]  n_row_base;

    t_depth             depth;
    logic [1:0]         shift;
    logic [COUNT_W-1:0] items;
    logic [COUNT_W-1:0] items_eff;
    logic [COUNT_W-1:0] height_eff;
    logic               eol;
    logic               eof;
    logic               is_fetch;
    logic [ADDR_W-1:0]  word_addr;
    logic [ADDR_W-1:0]  addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_en  <= 1'b0;
            r_mode_bits <= 3'd0;
            r_mode_map  <= 1'b0;
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
            r_stride    <= RST_STRIDE;
            r_skip      <= RST_SKIP;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_VIDEO_ENABLE:  r_video_en  <= i_cfg_data[0];
                CFG_MODE_BITS:     r_mode_bits <= i_cfg_data[2:0];
                CFG_MODE_MAP:      r_mode_map  <= i_cfg_data[0];
                CFG_ACTIVE_WIDTH:  r_width     <= i_cfg_data[COUNT_W-1:0];
                CFG_ACTIVE_HEIGHT: r_height    <= i_cfg_data[COUNT_W-1:0];
                CFG_ROW_STRIDE:    r_stride    <= i_cfg_data[PITCH_W-1:0];
                CFG_SKIP_BYTES:    r_skip      <= i_cfg_data[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && o_in_ready;
    assign is_fetch   = (i_in.op == OP_FETCH);

    always_comb begin
        depth      = depth_of(r_mode_map, r_mode_bits);
        shift      = (depth == DEPTH_DIRECT) ? 2'd0 : depth[1:0];
        items      = r_width >> shift;
        items_eff  = (items == '0) ? COUNT_W'(1) : items;
        height_eff = (r_height == '0) ? COUNT_W'(1) : r_height;
        // counters past their bounds close the line/frame as if at the bound
        eol = ({1'b0, r_col} + (COUNT_W+1)'(1)) >= {1'b0, items_eff};
        eof = eol && (({1'b0, r_line} + (COUNT_W+1)'(1)) >= {1'b0, height_eff});

        n_col      = r_col;
        n_line     = r_line;
        n_row_base = r_row_base;
        if (!is_fetch || eof) begin
            n_col      = '0;
            n_line     = '0;
            n_row_base = '0;
        end else if (eol) begin
            n_col      = '0;
            n_line     = r_line + COUNT_W'(1);
            n_row_base = r_row_base + ADDR_W'(r_stride);
        end else begin
            n_col = r_col + COUNT_W'(1);
        end

        word_addr = n_row_base + ADDR_W'(n_col);
        if (depth == DEPTH_DIRECT) begin
            addr = {word_addr[ADDR_W-3:0], 2'b00};
        end else begin
            addr = ADDR_W'(r_skip) + n_row_base + ADDR_W'(n_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_line     <= '0;
            r_row_base <= '0;
        end else if (o_push) begin
            r_col      <= n_col;
            r_line     <= n_line;
            r_row_base <= n_row_base;
        end
    end

    always_comb begin
        o_work.is_pixel     = is_fetch;
        o_work.depth        = depth;
        o_work.video_en     = r_video_en;
        o_work.eol          = eol;
        o_work.eof          = eof;
        o_work.next_address = addr;
        if (depth == DEPTH_DIRECT) begin
            o_work.data = i_in.fetch_data[RGB_W-1:0];
        end else begin
            o_work.data = {16'd0, i_in.fetch_data[7:0]};
        end
    end

endmodule

[design/pps_queue.sv]
`timescale 1ns / 1ps
// Short show-ahead queue of classified items between front and back.
// Uses t_work and the queue sizing from pps_pkg.
module pps_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pps_pkg::t_work i_work,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output pps_pkg::t_work o_work
);
    import pps_pkg::*;

    t_work             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_pop  = i_pop && o_valid;
    assign o_work  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (do_pop && !i_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_full |-> !i_push)
        else $error("push into a full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !do_pop) |=> (r_count == $past(r_count) + (QPTR_W+1)'(1)))
        else $error("queue count lost a push");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count overflow");

endmodule

[design/pps_back.sv]
`timescale 1ns / 1ps
// Back end: unpacks each queued item into its pixels, MSB first, one result
// per cycle unless stalled, to the output register; t_work/t_out: pps_pkg.
module pps_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  pps_pkg::t_work i_work,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pps_pkg::t_out  o_out
);
    import pps_pkg::*;

    logic [2:0]       r_k;
    logic             r_out_valid;
    t_out             r_out;
    t_out             n_out;
    logic [2:0]       ppi_m1;
    logic             is_last;
    logic             advance;
    logic [2:0]       bit_ofs;
    logic [7:0]       shifted;
    logic [RGB_W-1:0] pix;

    assign advance = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_pop   = advance && is_last;

    always_comb begin
        ppi_m1 = 3'd0;
        if (i_work.is_pixel) begin
            case (i_work.depth)
                DEPTH_4BPP: ppi_m1 = 3'd1;
                DEPTH_2BPP: ppi_m1 = 3'd3;
                DEPTH_1BPP: ppi_m1 = 3'd7;
                default:    ppi_m1 = 3'd0;
            endcase
        end
        is_last = (r_k == ppi_m1);

        // bring pixel k to the top of the byte, then take its bits
        case (i_work.depth)
            DEPTH_4BPP: bit_ofs = {r_k[0], 2'b00};
            DEPTH_2BPP: bit_ofs = {r_k[1:0], 1'b0};
            DEPTH_1BPP: bit_ofs = r_k;
            default:    bit_ofs = 3'd0;
        endcase
        shifted = i_work.data[7:0] << bit_ofs;

        case (i_work.depth)
            DEPTH_DIRECT: pix = i_work.data;
            DEPTH_4BPP:   pix = RGB_W'(shifted[7:4]);
            DEPTH_2BPP:   pix = RGB_W'(shifted[7:6]);
            DEPTH_1BPP:   pix = RGB_W'(shifted[7]);
            default:      pix = RGB_W'(shifted);
        endcase

        n_out = '0;
        n_out.last         = is_last;
        n_out.next_address = is_last ? i_work.next_address : '0;
        if (i_work.is_pixel) begin
            n_out.pixel_value     = i_work.video_en ? pix : '0;
            n_out.pixel_valid     = 1'b1;
            n_out.is_direct_color = (i_work.depth == DEPTH_DIRECT);
            n_out.line_end        = is_last && i_work.eol;
            n_out.frame_end       = is_last && i_work.eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_k         <= is_last ? 3'd0 : r_k + 3'd1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_out.next_address == '0))
        else $error("fetch address on a non-final result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.pixel_valid) |-> r_out.last)
        else $error("frame-start result not marked last");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_end) |-> (r_out.line_end && r_out.last))
        else $error("frame end without line end");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (r_k <= ppi_m1))
        else $error("pixel counter beyond item size");

endmodule

[design/packed_pixel_scanout.sv]
`timescale 1ns / 1ps
// Packed pixel scanout: each item passes the queue and the unpacker into the
// output register. Results leave at one per cycle unless the output stalls;
// an item gives 1 (8 bpp, direct), 2, 4 or 8 results, and the unpacker pops it with its last.
// A four-entry queue decouples input transfers from output stalls.
// Synchronous active-low reset: registers to defaults, counters zero, queue empty.
module packed_pixel_scanout (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pps_pkg::t_in                   i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pps_pkg::t_out                  o_out
);
    import pps_pkg::*;

    logic  q_full;
    logic  q_valid;
    logic  push;
    logic  pop;
    t_work front_work;
    t_work head_work;

    pps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_work      (front_work)
    );

    pps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_work  (head_work)
    );

    pps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_work      (head_work),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
